[sv/lsfa_pkg.sv]
package lsfa_pkg;

   // sizing
   localparam int NUM_SENSORS_DEF = 16;
   localparam int TABLE_MAX       = 16;   // loadable sensors (4-bit index)
   localparam int IDX_W           = 4;
   localparam int VAL_W           = 16;
   localparam int MASK_W          = 16;
   localparam int CNT_W           = 5;
   localparam int RUN_W           = 4;
   localparam int SUM_W           = 20;
   localparam int ERR_W           = 24;
   localparam int FRAC_W          = 8;
   localparam int DIV_W           = SUM_W + FRAC_W;
   localparam int DIV_CNT_W       = 5;
   localparam int REQ_DATA_W      = 56;
   localparam int RSP_DATA_W      = 56;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int RA_WIN_W        = 4;
   localparam int STAB_WIN_W      = 5;

   localparam logic [VAL_W-1:0] THR_RESET = 16'hFFFF;
   localparam logic [RUN_W-1:0] RUN_MAX   = 4'hF;

   // config reset values
   localparam logic [RA_WIN_W-1:0]   RA_WIN_RESET   = 4'd3;
   localparam logic [STAB_WIN_W-1:0] STAB_WIN_RESET = 5'd2;

   // request kinds (tuser)
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      CSR_RA_WINDOW   = 3'd0,
      CSR_STAB_WINDOW = 3'd1,
      CSR_ERR_THRESH  = 3'd2,
      CSR_FALLBACK_P  = 3'd3,
      CSR_FALLBACK_N  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [RA_WIN_W-1:0]   ra_window;
      logic [STAB_WIN_W-1:0] stab_window;
      logic [ERR_W-1:0]      err_threshold;
      logic [ERR_W-1:0]      fallback_pos;
      logic [ERR_W-1:0]      fallback_neg;
   } cfg_type;

   typedef struct packed {
      logic             cmd;
      logic [IDX_W-1:0] sensor_index;
      logic [VAL_W-1:0] sample_value;
      logic [VAL_W-1:0] threshold_value;
      logic [VAL_W-1:0] weight_value;
   } item_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic div_start;
      logic div_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_load;
      logic frame_last;
      logic count_zero;
   } dp_status_type;

   typedef struct packed {
      logic [MASK_W-1:0] active_mask;
      logic [CNT_W-1:0]  active_count;
      logic              any_line;
      logic              right_angle;
      logic              straight_line;
      logic              stabilized;
      logic [ERR_W-1:0]  line_error;
   } result_type;

endpackage

[sv/lsfa_csr.sv]
module lsfa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lsfa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lsfa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lsfa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output lsfa_pkg::cfg_type                 cfg
);
   import lsfa_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_RA_WINDOW:   cfg_in.ra_window     = csr_pwdata[RA_WIN_W-1:0];
            CSR_STAB_WINDOW: cfg_in.stab_window   = csr_pwdata[STAB_WIN_W-1:0];
            CSR_ERR_THRESH:  cfg_in.err_threshold = csr_pwdata[ERR_W-1:0];
            CSR_FALLBACK_P:  cfg_in.fallback_pos  = csr_pwdata[ERR_W-1:0];
            CSR_FALLBACK_N:  cfg_in.fallback_neg  = csr_pwdata[ERR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ra_window     <= RA_WIN_RESET;
         cfg_ff.stab_window   <= STAB_WIN_RESET;
         cfg_ff.err_threshold <= '0;
         cfg_ff.fallback_pos  <= '0;
         cfg_ff.fallback_neg  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // signed registers read back sign-extended
   always_comb begin
      case (index)
         CSR_RA_WINDOW:   csr_prdata = CSR_DATA_W'(cfg_ff.ra_window);
         CSR_STAB_WINDOW: csr_prdata = CSR_DATA_W'(cfg_ff.stab_window);
         CSR_ERR_THRESH:  csr_prdata = CSR_DATA_W'($signed(cfg_ff.err_threshold));
         CSR_FALLBACK_P:  csr_prdata = CSR_DATA_W'($signed(cfg_ff.fallback_pos));
         CSR_FALLBACK_N:  csr_prdata = CSR_DATA_W'($signed(cfg_ff.fallback_neg));
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[sv/lsfa_ctrl.sv]
module lsfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  lsfa_pkg::dp_status_type status,
   output lsfa_pkg::dp_cmd_type    cmd
);
   import lsfa_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   state_type             state_ff;
   state_type             state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  out_free;

   assign out_free = ~out_valid_ff | rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!status.is_load && status.frame_last) state_in = ST_FINISH;
            else                                      state_in = ST_IDLE;
         end
         ST_FINISH: begin
            if (status.count_zero) state_in = ST_EMIT;
            else                   state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      req_tready    = 1'b0;
      div_cnt_in    = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_FINISH: begin
            cmd.div_start = ~status.count_zero;
            div_cnt_in    = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: cmd = '0;
      endcase
      out_valid_in = cmd.emit | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

[sv/lsfa_dp.sv]
module lsfa_dp #(
   parameter int NUM_SENSORS = lsfa_pkg::NUM_SENSORS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lsfa_pkg::item_type      item,
   input  lsfa_pkg::cfg_type       cfg,
   input  lsfa_pkg::dp_cmd_type    cmd,
   output lsfa_pkg::dp_status_type status,
   output lsfa_pkg::result_type    result
);
   import lsfa_pkg::*;

   localparam int PW   = $clog2(NUM_SENSORS);
   localparam int HALF = NUM_SENSORS / 2;
   localparam int TD   = (NUM_SENSORS < TABLE_MAX) ? NUM_SENSORS : TABLE_MAX;
   localparam int TW   = $clog2(TD);
   localparam int MW   = (PW + 2 > 6) ? PW + 2 : 6;

   // calibration tables
   logic [VAL_W-1:0] thr_ff [TD];
   logic [VAL_W-1:0] wgt_ff [TD];

   item_type                item_ff;
   logic [PW-1:0]           pos_ff;
   logic [MASK_W-1:0]       mask_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    mid_seen_ff;
   logic                    outside_ff;
   logic [RUN_W-1:0]        run_ff;
   logic                    corner_ff;
   logic                    low_on_ff;
   logic                    high_on_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [ERR_W-1:0] last_err_ff;
   logic [DIV_W-1:0]        dvd_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic                    neg_ff;
   result_type              result_ff;

   logic                    pos_hit;
   logic                    ld_hit;
   logic [VAL_W-1:0]        cur_thr;
   logic [VAL_W-1:0]        cur_wgt;
   logic                    active;
   logic [MW-1:0]           s_win;
   logic [MW-1:0]           m_start;
   logic [MW-1:0]           m_end;
   logic [MW-1:0]           pos_m;
   logic                    in_mid;
   logic [RUN_W-1:0]        run_base;
   logic [RUN_W-1:0]        run_next;
   logic [SUM_W-1:0]        sum_abs;
   logic [CNT_W:0]          trial;
   logic                    trial_ge;
   logic [ERR_W-1:0]        quot;
   logic [ERR_W-1:0]        div_err;
   logic [ERR_W-1:0]        err_sel;

   // sample lookup; sensors past the loadable range never activate
   assign pos_hit = {1'b0, pos_ff} < (PW + 1)'(TD);
   assign ld_hit  = {1'b0, item_ff.sensor_index} < (IDX_W + 1)'(TD);
   assign cur_thr = pos_hit ? thr_ff[pos_ff[TW-1:0]] : THR_RESET;
   assign cur_wgt = pos_hit ? wgt_ff[pos_ff[TW-1:0]] : '0;
   assign active  = item_ff.sample_value > cur_thr;

   // centered middle window
   always_comb begin
      s_win   = (MW'(cfg.stab_window) > MW'(NUM_SENSORS)) ? MW'(NUM_SENSORS)
                                                          : MW'(cfg.stab_window);
      m_start = (MW'(NUM_SENSORS) - s_win) >> 1;
      m_end   = m_start + s_win;
      pos_m   = MW'(pos_ff);
      in_mid  = (pos_m >= m_start) && (pos_m < m_end);
   end

   // run counter restarts at the half boundary, saturates
   always_comb begin
      run_base = (pos_ff == PW'(HALF)) ? '0 : run_ff;
      if (!active)                 run_next = '0;
      else if (run_base != RUN_MAX) run_next = run_base + 1'b1;
      else                         run_next = run_base;
   end

   // restoring divide step, one quotient bit per cycle
   assign sum_abs  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial    = {rem_ff, dvd_ff[DIV_W-1]};
   assign trial_ge = trial >= {1'b0, count_ff};
   assign quot     = dvd_ff[ERR_W-1:0];
   assign div_err  = neg_ff ? ERR_W'(-quot) : quot;

   // error select: average, or on a lost line a fallback (last error when it equals the threshold)
   always_comb begin
      if (count_ff != '0)
         err_sel = div_err;
      else if ($signed(last_err_ff) > $signed(cfg.err_threshold))
         err_sel = cfg.fallback_pos;
      else if ($signed(last_err_ff) < $signed(cfg.err_threshold))
         err_sel = cfg.fallback_neg;
      else
         err_sel = last_err_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) item_ff <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TD; i++) begin
            thr_ff[i] <= THR_RESET;
            wgt_ff[i] <= '0;
         end
      end else if (cmd.exec && item_ff.cmd == CMD_LOAD && ld_hit) begin
         thr_ff[item_ff.sensor_index[TW-1:0]] <= item_ff.threshold_value;
         wgt_ff[item_ff.sensor_index[TW-1:0]] <= item_ff.weight_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         pos_ff      <= '0;
         mask_ff     <= '0;
         count_ff    <= '0;
         mid_seen_ff <= 1'b0;
         outside_ff  <= 1'b0;
         run_ff      <= '0;
         corner_ff   <= 1'b0;
         low_on_ff   <= 1'b0;
         high_on_ff  <= 1'b0;
         sum_ff      <= '0;
      end else if (cmd.exec && item_ff.cmd == CMD_SAMPLE) begin
         pos_ff <= status.frame_last ? '0 : pos_ff + 1'b1;
         run_ff <= run_next;
         if (run_next >= cfg.ra_window) corner_ff <= 1'b1;
         if (active) begin
            mask_ff  <= mask_ff | (MASK_W'(1) << pos_ff);
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_W'($signed(cur_wgt));
            if (in_mid) mid_seen_ff <= 1'b1;
            else        outside_ff  <= 1'b1;
            if (pos_ff == PW'(HALF - 1)) low_on_ff  <= 1'b1;
            if (pos_ff == PW'(HALF))     high_on_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= {sum_abs, FRAC_W'(0)};
         rem_ff <= '0;
         neg_ff <= sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
         dvd_ff <= {dvd_ff[DIV_W-2:0], trial_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset)          last_err_ff <= '0;
      else if (cmd.emit)  last_err_ff <= err_sel;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         result_ff.active_mask   <= mask_ff;
         result_ff.active_count  <= count_ff;
         result_ff.any_line      <= count_ff != '0;
         result_ff.right_angle   <= corner_ff;
         result_ff.straight_line <= (count_ff == CNT_W'(2)) && low_on_ff && high_on_ff;
         result_ff.stabilized    <= ~outside_ff & mid_seen_ff;
         result_ff.line_error    <= err_sel;
      end
   end

   assign status.is_load    = item_ff.cmd == CMD_LOAD;
   assign status.frame_last = pos_ff == PW'(NUM_SENSORS - 1);
   assign status.count_zero = count_ff == '0;
   assign result            = result_ff;

endmodule

[sv/line_sensor_frame_analyzer_core.sv]
// Line sensor frame analyzer: one result per frame of NUM_SENSORS samples.
// Every item (sample or load) passes an accept state, then an execute state.
// The last sample of a frame adds a finish state, the steps of the DIV_W-bit (28-bit)
// bit-serial divider when any sensor is active, and a result-load state.
// A held result stalls the frame in the result-load state.
// Synchronous active-high reset: thresholds all ones, weights and state zero.
module line_sensor_frame_analyzer_core #(
   parameter int NUM_SENSORS = lsfa_pkg::NUM_SENSORS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [3:0] sensor_index, [19:4] sample_value, [35:20] threshold_value,
   // [51:36] weight_value, [55:52] zero
   input  logic [lsfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd (0 sample, 1 load)
   input  logic [0:0]                          req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] active_mask, [20:16] active_count, [21] any_line,
   // [22] right_angle, [23] straight_line, [24] stabilized,
   // [48:25] line_error, [55:49] zero
   output logic [lsfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lsfa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lsfa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lsfa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import lsfa_pkg::*;

   cfg_type       cfg;
   item_type      item;
   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;

   // unpack request transfer
   assign item.cmd             = req_tuser[0];
   assign item.sensor_index    = req_tdata[3:0];
   assign item.sample_value    = req_tdata[19:4];
   assign item.threshold_value = req_tdata[35:20];
   assign item.weight_value    = req_tdata[51:36];

   // zero-wait register port
   assign csr_pready = 1'b1;

   lsfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // sequencer: item handshake, divider steps, result register handoff
   lsfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // tables, frame accumulators, divider and result register
   lsfa_dp #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

   // pack result transfer
   assign rsp_tdata = {7'd0,
                       result.line_error,
                       result.stabilized,
                       result.straight_line,
                       result.right_angle,
                       result.any_line,
                       result.active_count,
                       result.active_mask};

   // one item in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous item still executing");

   // any_line tracks the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.any_line == (result.active_count != '0)))
      else $error("any_line disagrees with active_count");

   // straight line means exactly two active sensors
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.straight_line) |-> (result.active_count == CNT_W'(2)))
      else $error("straight_line with active_count other than two");

   // stabilized needs at least one active sensor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.stabilized) |-> result.any_line)
      else $error("stabilized with no active sensor");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
   import lsfa_pkg::*;

   localparam int N = NUM_SENSORS_DEF;
   localparam int HALF = N / 2;
   // one frame plus the serial divide, with margin; also covers load-only tails
   localparam int SETTLE_CYCLES = 2 * N + 48;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid, req_tready;
   // [3:0] sensor_index, [19:4] sample_value, [35:20] threshold_value,
   // [51:36] weight_value, [55:52] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   // [0] cmd
   logic [0:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   // [15:0] active_mask, [20:16] active_count, [21] any_line, [22] right_angle,
   // [23] straight_line, [24] stabilized, [48:25] line_error
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   always #2 clock = ~clock;

   line_sensor_frame_analyzer_core #(.NUM_SENSORS(N)) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   // ---------------------------------------------------------------
   // frame scorer: calibration tables, running frame sums, registers
   // ---------------------------------------------------------------
   logic [VAL_W-1:0]        thr_tab [N];
   logic signed [VAL_W-1:0] wt_tab  [N];
   int                frame_pos, acc_count, acc_mid, run_len, wsum, last_err;
   logic [MASK_W-1:0] acc_mask;
   bit                acc_outside, acc_corner, lo_on, hi_on;
   int                ra_win, stab_win, err_thr, fb_pos, fb_neg;

   result_type expected_scores[$];
   int         score_errors = 0;
   bit         req_gaps, rsp_stalls;

   function automatic int sext24(logic [CSR_DATA_W-1:0] value);
      logic signed [ERR_W-1:0] s;
      s = value[ERR_W-1:0];
      return int'(s);
   endfunction

   function automatic void clear_frame_state();
      frame_pos   = 0;
      acc_mask    = '0;
      acc_count   = 0;
      acc_mid     = 0;
      acc_outside = 1'b0;
      run_len     = 0;
      acc_corner  = 1'b0;
      wsum        = 0;
      lo_on       = 1'b0;
      hi_on       = 1'b0;
   endfunction

   function automatic void apply_calibration(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] thr,
                                             logic [VAL_W-1:0] wt);
      if (idx < N) begin
         thr_tab[idx] = thr;
         wt_tab[idx]  = wt;
      end
   endfunction

   // Scores one sample; at the last sensor pushes the frame's expected result.
   function automatic void score_sample(logic [VAL_W-1:0] value);
      int         s_win, m_lo, err;
      bit         lit;
      result_type r;
      lit   = value > thr_tab[frame_pos];
      s_win = (stab_win > N) ? N : stab_win;
      m_lo  = (N - s_win) / 2;
      if (frame_pos == HALF) run_len = 0;   // a run never spans both halves
      if (lit) begin
         if (frame_pos < MASK_W) acc_mask[frame_pos] = 1'b1;
         acc_count++;
         wsum += wt_tab[frame_pos];
         if (frame_pos >= m_lo && frame_pos < m_lo + s_win) acc_mid++;
         else acc_outside = 1'b1;
         if (frame_pos == HALF - 1) lo_on = 1'b1;
         if (frame_pos == HALF) hi_on = 1'b1;
         if (run_len < 15) run_len++;
      end else begin
         run_len = 0;
      end
      if (run_len >= ra_win) acc_corner = 1'b1;
      if (frame_pos + 1 < N) begin
         frame_pos++;
         return;
      end
      // weighted mean in Q.8, truncated toward zero; else fallback (or last error at the threshold) on lost line
      if (acc_count > 0) err = int'((longint'(wsum) * 256) / acc_count);
      else if (last_err > err_thr) err = fb_pos;
      else if (last_err < err_thr) err = fb_neg;
      else err = last_err;
      last_err = err;
      r.active_mask   = acc_mask;
      r.active_count  = CNT_W'(acc_count);
      r.any_line      = acc_count > 0;
      r.right_angle   = acc_corner;
      r.straight_line = acc_count == 2 && lo_on && hi_on;
      r.stabilized    = !acc_outside && acc_mid >= 1;
      r.line_error    = err[ERR_W-1:0];
      expected_scores.push_back(r);
      clear_frame_state();
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         score_errors++;
         $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] smp, input logic [VAL_W-1:0] thr,
                            input logic [VAL_W-1:0] wt);
      int gap;
      gap = req_gaps ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, wt, thr, smp, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_LOAD) apply_calibration(idx, thr, wt);
      else score_sample(smp);
   endtask

   // APB write; psel stays up so back-to-back writes go straight to setup
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         CSR_RA_WINDOW:   ra_win   = value[RA_WIN_W-1:0];
         CSR_STAB_WINDOW: stab_win = value[STAB_WIN_W-1:0];
         CSR_ERR_THRESH:  err_thr  = sext24(value);
         CSR_FALLBACK_P:  fb_pos   = sext24(value);
         CSR_FALLBACK_N:  fb_neg   = sext24(value);
         default: ;
      endcase
   endtask

   // drain: every result back, then let trailing loads finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_load();
      logic [VAL_W-1:0] thr;
      case ($urandom_range(0, 7))
         0:       thr = '0;
         1:       thr = THR_RESET;
         default: thr = VAL_W'($urandom);
      endcase
      send_item(CMD_LOAD, IDX_W'($urandom), VAL_W'($urandom), thr, VAL_W'($urandom));
   endtask

   // activity patterns aimed at each flag
   function automatic logic [MASK_W-1:0] pick_pattern();
      int len, lo, hi, s_win;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return MASK_W'(3) << (HALF - 1);              // two middle sensors
         2: begin                                         // run inside one half
            len = $urandom_range(1, HALF);
            lo  = $urandom_range(0, HALF - len) + HALF * $urandom_range(0, 1);
            return MASK_W'((1 << len) - 1) << lo;
         end
         3: begin                                         // cluster in middle window
            s_win = (stab_win > N) ? N : stab_win;
            if (s_win == 0) return MASK_W'(1) << HALF;
            lo = (N - s_win) / 2 + $urandom_range(0, s_win - 1);
            hi = $urandom_range(lo, (N - s_win) / 2 + s_win - 1);
            return MASK_W'((1 << (hi - lo + 1)) - 1) << lo;
         end
         4: return '1;
         default: return MASK_W'($urandom);
      endcase
   endfunction

   // samples placed above the current thresholds when active, at or below them when not, or random when noisy
   task automatic send_frame(input logic [MASK_W-1:0] pattern, input bit noisy);
      logic [VAL_W-1:0] v, t;
      for (int i = 0; i < N; i++) begin
         if ($urandom_range(0, 15) == 0) send_random_load();   // mid-frame load
         t = thr_tab[i];
         if (noisy) v = VAL_W'($urandom);
         else if (pattern[i] && t != THR_RESET) v = VAL_W'($urandom_range(THR_RESET, t + 1));
         else if (pattern[i]) v = THR_RESET;
         else v = VAL_W'($urandom_range(t, 0));
         send_item(CMD_SAMPLE, IDX_W'($urandom), v, VAL_W'($urandom), VAL_W'($urandom));
      end
   endtask

   task automatic run_phase(input int ra, input int stab, input int thr, input int fp,
                            input int fn, input int frames, input bit lost);
      int mode;
      settle();
      mode       = $urandom_range(0, 3);
      req_gaps   = mode[0];
      rsp_stalls = mode[1];
      csr_write(CSR_RA_WINDOW, ra);
      csr_write(CSR_STAB_WINDOW, stab);
      csr_write(CSR_ERR_THRESH, thr);
      csr_write(CSR_FALLBACK_P, fp);
      csr_write(CSR_FALLBACK_N, fn);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      repeat (6) send_random_load();
      // lost mode: every other frame gets an empty pattern (unless noisy), exercising the fallback
      for (int f = 0; f < frames; f++)
         send_frame((lost && f % 2 == 1) ? '0 : pick_pattern(), $urandom_range(0, 7) == 0);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // Reset tables: only loaded sensors can fire. Extreme weights, thresholds
   // and samples; a load mid-frame to an already scored sensor.
   task automatic test_directed_extremes();
      send_item(CMD_LOAD, IDX_W'(N - 1), 16'h0000, 16'h0000, 16'h7FFF);
      send_item(CMD_LOAD, IDX_W'(N - 2), 16'hFFFF, 16'hFFFE, 16'h8000);
      for (int i = 0; i < N; i++) begin
         if (i == 4) send_item(CMD_LOAD, '0, 16'h5555, 16'h0000, 16'h8000);
         send_item(CMD_SAMPLE, IDX_W'(i), (i % 2 == 1 || i >= N - 2) ? THR_RESET : 16'h0000,
                   16'hAAAA, 16'h5A5A);
      end
   endtask

   // zero window (always set), one, exactly a half, longer than a half, max
   task automatic test_right_angle_window();
      int wins[5] = '{0, 1, HALF, HALF + 1, 15};
      foreach (wins[k]) run_phase(wins[k], STAB_WIN_RESET, 0, 0, 0, 3, 1'b0);
   endtask

   // empty window, odd width, whole frame, wider than the frame, max
   task automatic test_stabilize_window();
      int wins[5] = '{0, 1, N, N + 1, 31};
      foreach (wins[k]) run_phase(RA_WIN_RESET, wins[k], 0, 0, 0, 3, 1'b0);
   endtask

   task automatic test_lost_line_fallback();
      run_phase(RA_WIN_RESET, STAB_WIN_RESET, -8388608, 8388607, -8388608, 6, 1'b1);
      run_phase(RA_WIN_RESET, STAB_WIN_RESET, 8388607, -8388608, 8388607, 6, 1'b1);
      run_phase(RA_WIN_RESET, STAB_WIN_RESET, sext24($urandom), sext24($urandom),
                sext24($urandom), 6, 1'b1);
   endtask

   task automatic test_random_mix();
      repeat (4)
         run_phase($urandom_range(0, 15), $urandom_range(0, 31), sext24($urandom),
                   sext24($urandom), sext24($urandom), 3, 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------
   // result sink: random stalls, in-order compare
   // ---------------------------------------------------------------
   initial begin : score_checker
      int         hold;
      result_type want;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (rsp_tready && rsp_tvalid) begin
            if (expected_scores.size() == 0) begin
               score_errors++;
               $display("%0t unexpected transfer: expected none, got %h", $time, rsp_tdata);
            end else begin
               want = expected_scores.pop_front();
               compare_field("active_mask", want.active_mask, rsp_tdata[15:0]);
               compare_field("active_count", want.active_count, rsp_tdata[20:16]);
               compare_field("any_line", want.any_line, rsp_tdata[21]);
               compare_field("right_angle", want.right_angle, rsp_tdata[22]);
               compare_field("straight_line", want.straight_line, rsp_tdata[23]);
               compare_field("stabilized", want.stabilized, rsp_tdata[24]);
               compare_field("line_error", $signed(want.line_error), $signed(rsp_tdata[48:25]));
            end
            hold = rsp_stalls ? $urandom_range(0, 19) : 0;
            if (hold != 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (hold != 0) hold--;
            if (hold == 0) rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #1500000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      for (int i = 0; i < N; i++) begin
         thr_tab[i] = THR_RESET;
         wt_tab[i]  = '0;
      end
      clear_frame_state();
      last_err   = 0;
      ra_win     = RA_WIN_RESET;
      stab_win   = STAB_WIN_RESET;
      err_thr    = 0;
      fb_pos     = 0;
      fb_neg     = 0;
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_right_angle_window();
      test_stabilize_window();
      test_lost_line_fallback();
      test_random_mix();
      settle();

      if (score_errors == 0 && expected_scores.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[line_sensor_frame_analyzer_core.f]
sv/lsfa_pkg.sv
sv/lsfa_csr.sv
sv/lsfa_ctrl.sv
sv/lsfa_dp.sv
sv/line_sensor_frame_analyzer_core.sv
tb/sv/testbench.sv
